// ===== sv/mtc_pkg.sv =====
// mtc_pkg: shared types, character constants and code tables for the morse text codec
// no dependencies; used by every other file of the block

package mtc_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [2:0] BAD_COUNT = 3'd7;
	localparam logic [2:0] MAX_SYMBOLS = 3'd4;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		DIR_ENCODE = 1'b0,
		DIR_DECODE = 1'b1
	} dir_t;

	// one queued job: a run of morse symbols, then one or two tail results
	typedef struct packed {
		logic [3:0] sym_bits;
		logic [2:0] sym_len;
		logic t1_vld;
		logic [7:0] t1_char;
		status_t t1_status;
		logic t2_vld;
		logic [7:0] t2_char;
		status_t t2_status;
	} job_t;

	typedef struct packed {
		logic vld;
		logic [2:0] len;
		logic [3:0] bits;
	} enc_t;

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// letter to code, bit i set = symbol i is a dash
	function automatic enc_t encode_letter(input logic [7:0] c);
		logic [7:0] lc;
		enc_t r;
		lc = (c >= "A" && c <= "Z") ? (c + 8'd32) : c;
		r = '{vld: 1'b1, len: 3'd0, bits: 4'b0000};
		case (lc)
			"a": begin r.len = 3'd2; r.bits = 4'b0010; end
			"b": begin r.len = 3'd4; r.bits = 4'b0001; end
			"c": begin r.len = 3'd4; r.bits = 4'b0101; end
			"d": begin r.len = 3'd3; r.bits = 4'b0001; end
			"e": begin r.len = 3'd1; r.bits = 4'b0000; end
			"f": begin r.len = 3'd4; r.bits = 4'b0100; end
			"g": begin r.len = 3'd3; r.bits = 4'b0011; end
			"h": begin r.len = 3'd4; r.bits = 4'b0000; end
			"i": begin r.len = 3'd2; r.bits = 4'b0000; end
			"j": begin r.len = 3'd4; r.bits = 4'b1110; end
			"k": begin r.len = 3'd3; r.bits = 4'b0101; end
			"l": begin r.len = 3'd4; r.bits = 4'b0010; end
			"m": begin r.len = 3'd2; r.bits = 4'b0011; end
			"n": begin r.len = 3'd2; r.bits = 4'b0001; end
			"o": begin r.len = 3'd3; r.bits = 4'b0111; end
			"p": begin r.len = 3'd4; r.bits = 4'b0110; end
			"r": begin r.len = 3'd3; r.bits = 4'b0010; end
			"s": begin r.len = 3'd3; r.bits = 4'b0000; end
			"t": begin r.len = 3'd1; r.bits = 4'b0001; end
			"u": begin r.len = 3'd3; r.bits = 4'b0100; end
			"v": begin r.len = 3'd4; r.bits = 4'b1000; end
			"w": begin r.len = 3'd3; r.bits = 4'b0110; end
			"x": begin r.len = 3'd4; r.bits = 4'b1001; end
			"y": begin r.len = 3'd4; r.bits = 4'b1101; end
			"z": begin r.len = 3'd4; r.bits = 4'b0011; end
			default: r.vld = 1'b0;
		endcase
		encode_letter = r;
	endfunction

	// code to lowercase letter, CH_NUL when unknown
	function automatic logic [7:0] decode_code(input logic [2:0] cnt, input logic [3:0] bits);
		logic [7:0] r;
		case ({cnt, bits})
			{3'd2, 4'b0010}: r = "a";
			{3'd4, 4'b0001}: r = "b";
			{3'd4, 4'b0101}: r = "c";
			{3'd3, 4'b0001}: r = "d";
			{3'd1, 4'b0000}: r = "e";
			{3'd4, 4'b0100}: r = "f";
			{3'd3, 4'b0011}: r = "g";
			{3'd4, 4'b0000}: r = "h";
			{3'd2, 4'b0000}: r = "i";
			{3'd4, 4'b1110}: r = "j";
			{3'd3, 4'b0101}: r = "k";
			{3'd4, 4'b0010}: r = "l";
			{3'd2, 4'b0011}: r = "m";
			{3'd2, 4'b0001}: r = "n";
			{3'd3, 4'b0111}: r = "o";
			{3'd4, 4'b0110}: r = "p";
			{3'd3, 4'b0010}: r = "r";
			{3'd3, 4'b0000}: r = "s";
			{3'd1, 4'b0001}: r = "t";
			{3'd3, 4'b0100}: r = "u";
			{3'd4, 4'b1000}: r = "v";
			{3'd3, 4'b0110}: r = "w";
			{3'd4, 4'b1001}: r = "x";
			{3'd4, 4'b1101}: r = "y";
			{3'd4, 4'b0011}: r = "z";
			default: r = CH_NUL;
		endcase
		decode_code = r;
	endfunction

endpackage

// ===== sv/mtc_if.sv =====
// mtc_if: channel interfaces of the morse text codec (text in, results out, config)
// depends on mtc_pkg

interface mtc_in_if;
	logic valid;
	logic ready;
	logic [7:0] in_char;
	logic end_of_input;
	modport source (output valid, output in_char, output end_of_input, input ready);
	modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

interface mtc_out_if;
	import mtc_pkg::*;
	logic valid;
	logic ready;
	logic [7:0] out_char;
	status_t status;
	logic last;
	modport source (output valid, output out_char, output status, output last, input ready);
	modport sink (input valid, input out_char, input status, input last, output ready);
endinterface

interface mtc_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source (output valid, output direction, input ready);
	modport sink (input valid, input direction, output ready);
endinterface

// ===== sv/mtc_front.sv =====
// mtc_front: accepts text beats and config writes, keeps the stream state, builds jobs
// depends on mtc_pkg and mtc_if

module mtc_front
	import mtc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	mtc_in_if.sink text_in,
	mtc_cfg_if.sink cfg,
	output logic push,
	output job_t push_job,
	input logic push_ready
);

	dir_t direction_q;
	logic [3:0] sym_bits_q, sym_bits_d;
	logic [2:0] sym_cnt_q, sym_cnt_d;
	logic prev_slash_q, prev_slash_d;
	logic in_word_q, in_word_d;
	logic seen_q, seen_d;
	logic err_q, err_d;
	logic accept;
	logic [7:0] c;
	enc_t enc;
	logic [7:0] dec;

	assign cfg.ready = 1'b1;
	assign text_in.ready = push_ready;
	assign accept = text_in.valid && text_in.ready;
	assign c = text_in.in_char;
	assign enc = encode_letter(c);
	assign dec = decode_code(sym_cnt_q, sym_bits_q);

	always_comb begin
		sym_bits_d = sym_bits_q;
		sym_cnt_d = sym_cnt_q;
		prev_slash_d = prev_slash_q;
		in_word_d = in_word_q;
		seen_d = seen_q;
		err_d = err_q;
		push_job = '{sym_bits: 4'b0000, sym_len: 3'd0, t1_vld: 1'b0, t1_char: CH_NUL,
			t1_status: ST_OK, t2_vld: 1'b0, t2_char: CH_NUL, t2_status: ST_OK};
		if (err_q) begin
			push_job.t1_vld = 1'b1;
			push_job.t1_status = ST_BAD;
		end else if (text_in.end_of_input) begin
			if (direction_q == DIR_ENCODE && in_word_q) begin
				push_job.t1_vld = 1'b1;
				push_job.t1_char = CH_SLASH;
				push_job.t2_vld = !seen_q;
				push_job.t2_status = ST_EMPTY;
			end else begin
				push_job.t1_vld = !seen_q;
				push_job.t1_status = ST_EMPTY;
			end
			sym_bits_d = 4'b0000;
			sym_cnt_d = 3'd0;
			prev_slash_d = 1'b0;
			in_word_d = 1'b0;
			seen_d = 1'b0;
		end else if (direction_q == DIR_ENCODE) begin
			if (is_space(c)) begin
				if (in_word_q) begin
					push_job.t1_vld = 1'b1;
					push_job.t1_char = CH_SLASH;
					in_word_d = 1'b0;
				end
			end else if (enc.vld) begin
				push_job.sym_bits = enc.bits;
				push_job.sym_len = enc.len;
				push_job.t1_vld = 1'b1;
				push_job.t1_char = CH_SLASH;
				in_word_d = 1'b1;
				seen_d = 1'b1;
			end else begin
				err_d = 1'b1;
				push_job.t1_vld = 1'b1;
				push_job.t1_status = ST_BAD;
			end
		end else begin
			if (is_space(c)) begin
				prev_slash_d = 1'b0;
			end else if (c == CH_SLASH) begin
				seen_d = 1'b1;
				push_job.t1_vld = 1'b1;
				if (prev_slash_q) begin
					push_job.t1_char = CH_SPACE;
				end else if (dec == CH_NUL) begin
					err_d = 1'b1;
					push_job.t1_status = ST_BAD;
				end else begin
					push_job.t1_char = dec;
				end
				prev_slash_d = 1'b1;
				sym_bits_d = 4'b0000;
				sym_cnt_d = 3'd0;
			end else begin
				prev_slash_d = 1'b0;
				if (c != CH_DOT && c != CH_DASH) begin
					sym_cnt_d = BAD_COUNT;
				end else if (sym_cnt_q < MAX_SYMBOLS) begin
					if (c == CH_DASH) begin
						sym_bits_d = sym_bits_q | (4'b0001 << sym_cnt_q[1:0]);
					end
					sym_cnt_d = sym_cnt_q + 3'd1;
				end else begin
					sym_cnt_d = BAD_COUNT;
				end
			end
		end
	end

	assign push = accept && push_job.t1_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_DECODE;
			sym_bits_q <= 4'b0000;
			sym_cnt_q <= 3'd0;
			prev_slash_q <= 1'b0;
			in_word_q <= 1'b0;
			seen_q <= 1'b0;
			err_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				direction_q <= dir_t'(cfg.direction);
			end
			if (accept) begin
				sym_bits_q <= sym_bits_d;
				sym_cnt_q <= sym_cnt_d;
				prev_slash_q <= prev_slash_d;
				in_word_q <= in_word_d;
				seen_q <= seen_d;
				err_q <= err_d;
			end
		end
	end

endmodule

// ===== sv/mtc_queue.sv =====
// mtc_queue: small job queue between front and back
// depends on mtc_pkg

module mtc_queue
	import mtc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	output logic push_ready,
	output logic pop_valid,
	output job_t pop_job,
	input logic pop
);

	job_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job = entry_q[rd_ptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/mtc_back.sv =====
// mtc_back: plays a job from its register as result beats, one per cycle while ready
// depends on mtc_pkg and mtc_if

module mtc_back
	import mtc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	input job_t pop_job,
	output logic pop,
	mtc_out_if.source text_out
);

	job_t cur_q;
	logic cur_vld_q;
	logic fire;
	logic is_last;

	assign is_last = (cur_q.sym_len == 3'd0) && !cur_q.t2_vld;
	assign fire = text_out.valid && text_out.ready;
	assign pop = !cur_vld_q || (fire && is_last);

	always_comb begin
		text_out.valid = cur_vld_q;
		text_out.last = is_last;
		if (cur_q.sym_len != 3'd0) begin
			text_out.out_char = cur_q.sym_bits[0] ? CH_DASH : CH_DOT;
			text_out.status = ST_OK;
		end else begin
			text_out.out_char = cur_q.t1_char;
			text_out.status = cur_q.t1_status;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_valid) begin
			cur_q <= pop_job;
		end else if (fire) begin
			if (cur_q.sym_len != 3'd0) begin
				cur_q.sym_len <= cur_q.sym_len - 3'd1;
				cur_q.sym_bits <= {1'b0, cur_q.sym_bits[3:1]};
			end else begin
				cur_q.t1_char <= cur_q.t2_char;
				cur_q.t1_status <= cur_q.t2_status;
				cur_q.t2_vld <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
		end else if (pop) begin
			cur_vld_q <= pop_valid;
		end
	end

endmodule

// ===== sv/morse_text_codec.sv =====
// morse_text_codec: top level, front stage, job queue and result player
// depends on mtc_pkg, mtc_if, mtc_front, mtc_queue, mtc_back

// Translates a text stream one byte per input beat, letters to Morse when direction is 0
// and Morse to letters when it is 1 (reset value 1), over a 25-letter table without q.
// The input side takes a beat every cycle while the two-entry job queue has room; while
// it is full every beat waits, including beats that give no result (whitespace, gathered
// symbols). Each result beat is one transfer on the output channel, one per cycle while
// the output is ready, so a letter being encoded yields up to five result beats (four
// symbols and the closing slash) and the result player, not the input side, sets the
// sustained rate. Errors are sticky until reset; config writes are always ready and
// take effect in the cycle after the write.

module morse_text_codec
	import mtc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	mtc_in_if.sink text_in,
	mtc_out_if.source text_out,
	mtc_cfg_if.sink cfg
);

	logic push, push_ready;
	job_t push_job;
	logic pop, pop_valid;
	job_t pop_job;

	mtc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text_in(text_in),
		.cfg(cfg),
		.push(push),
		.push_job(push_job),
		.push_ready(push_ready)
	);

	mtc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.push_ready(push_ready),
		.pop_valid(pop_valid),
		.pop_job(pop_job),
		.pop(pop)
	);

	mtc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_job(pop_job),
		.pop(pop),
		.text_out(text_out)
	);

`ifndef SYNTHESIS
	a_push_has_tail: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_job.t1_vld && push_ready)
		else $error("job pushed without a tail result or into a full queue");

	a_bad_status_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		text_out.valid && text_out.status != ST_OK |-> text_out.out_char == CH_NUL)
		else $error("error result carries a character");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_out.valid && text_out.status == ST_EMPTY |-> text_out.last)
		else $error("empty input status not on the final beat");
`endif

endmodule
